// ===== hw/rtl/wsfu_pkg.sv =====
package wsfu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned SkipW = 4;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned KeyIdxW = 2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [SkipW-1:0] SKIP_EXT16 = 4'd2;
  localparam logic [SkipW-1:0] SKIP_EXT64 = 4'd8;
  localparam logic [SkipW-1:0] SKIP_KEY   = 4'd4;

  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [KindW-1:0] KIND_TEXT  = 2'd0;
  localparam logic [KindW-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KindW-1:0] KIND_PING  = 2'd2;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd3;

  typedef enum logic [5:0] {
    PH_OPCODE  = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DROP    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic [KindW-1:0] frame_kind;
    logic             frame_end;
  } result_t;

endpackage

// ===== hw/rtl/wsfu_in_stage.sv =====
module wsfu_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [wsfu_pkg::ByteW-1:0] rx_byte,
  input  logic                      buffer_end,
  input  logic                      downstream_free,
  output logic                      held_valid,
  output logic [wsfu_pkg::ByteW-1:0] held_byte,
  output logic                      held_end
);
  import wsfu_pkg::*;

  logic load;

  assign byte_stall = held_valid && !downstream_free;
  assign load = !held_valid || downstream_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && byte_valid) begin
      held_byte <= rx_byte;
      held_end  <= buffer_end;
    end
  end

endmodule

// ===== hw/rtl/wsfu_parser.sv =====
module wsfu_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [wsfu_pkg::ByteW-1:0] rx_byte,
  input  logic                      buffer_end,
  output logic                      emit,
  output wsfu_pkg::result_t         res
);
  import wsfu_pkg::*;

  phase_t             parse_phase, parse_phase_next;
  logic [SkipW-1:0]   skip_count, skip_count_next;
  logic               mask_enabled, mask_enabled_next;
  logic [KeyW-1:0]    mask_key, mask_key_next;
  logic [KeyIdxW-1:0] key_index, key_index_next;
  logic [KindW-1:0]   current_kind, current_kind_next;

  logic [SkipW-1:0]   skip_dec;
  logic [KeyIdxW-1:0] key_pos;
  logic [ByteW-1:0]   key_byte;
  logic [6:0]         len_code;
  logic [3:0]         opcode;
  logic               header_done;

  assign skip_dec = skip_count - 4'd1;
  assign key_pos  = KeyIdxW'(3'd4 - 3'(skip_count));
  assign key_byte = mask_enabled ? mask_key[key_index*ByteW +: ByteW] : '0;
  assign len_code = rx_byte[6:0];
  assign opcode   = rx_byte[3:0];

  always_comb begin
    parse_phase_next  = parse_phase;
    skip_count_next   = skip_count;
    mask_enabled_next = mask_enabled;
    mask_key_next     = mask_key;
    key_index_next    = key_index;
    current_kind_next = current_kind;
    emit              = 1'b0;
    res               = '0;
    header_done       = 1'b1;

    case (parse_phase)
      PH_DROP: begin
        header_done = 1'b0;
        if (buffer_end) begin
          parse_phase_next = PH_OPCODE;
        end
      end
      PH_PAYLOAD: begin
        header_done       = 1'b0;
        emit              = 1'b1;
        res.payload_byte  = rx_byte ^ key_byte;
        res.payload_valid = 1'b1;
        res.frame_kind    = current_kind;
        res.frame_end     = buffer_end;
        key_index_next    = key_index + 2'd1;
        if (buffer_end) begin
          parse_phase_next = PH_OPCODE;
        end
      end
      PH_LENGTH: begin
        mask_enabled_next = rx_byte[7];
        mask_key_next     = '0;
        key_index_next    = '0;
        if (len_code == LEN_EXT16) begin
          skip_count_next  = SKIP_EXT16;
          parse_phase_next = PH_EXT;
        end else if (len_code == LEN_EXT64) begin
          skip_count_next  = SKIP_EXT64;
          parse_phase_next = PH_EXT;
        end else if (rx_byte[7]) begin
          skip_count_next  = SKIP_KEY;
          parse_phase_next = PH_KEY;
        end else begin
          skip_count_next  = '0;
          parse_phase_next = PH_PAYLOAD;
        end
      end
      PH_EXT: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          if (mask_enabled) begin
            skip_count_next  = SKIP_KEY;
            parse_phase_next = PH_KEY;
          end else begin
            key_index_next   = '0;
            parse_phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_KEY: begin
        mask_key_next = mask_key | (KeyW'(rx_byte) << (key_pos * ByteW));
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          key_index_next   = '0;
          parse_phase_next = PH_PAYLOAD;
        end
      end
      default: begin
        parse_phase_next = PH_LENGTH;
        if (opcode == OP_TEXT) begin
          current_kind_next = KIND_TEXT;
        end else if (opcode == OP_CLOSE || opcode == OP_PONG) begin
          current_kind_next = KIND_CLOSE;
        end else if (opcode == OP_PING) begin
          current_kind_next = KIND_PING;
        end else begin
          header_done       = 1'b0;
          current_kind_next = KIND_ERROR;
          emit              = 1'b1;
          res.frame_kind    = KIND_ERROR;
          res.frame_end     = 1'b1;
          parse_phase_next  = buffer_end ? PH_OPCODE : PH_DROP;
        end
      end
    endcase

    // buffer ran out inside the header: end marker only
    if (header_done && buffer_end) begin
      emit             = 1'b1;
      res.frame_kind   = current_kind_next;
      res.frame_end    = 1'b1;
      parse_phase_next = PH_OPCODE;
      skip_count_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase  <= PH_OPCODE;
      skip_count   <= '0;
      mask_enabled <= 1'b0;
      mask_key     <= '0;
      key_index    <= '0;
      current_kind <= KIND_TEXT;
    end else if (step) begin
      parse_phase  <= parse_phase_next;
      skip_count   <= skip_count_next;
      mask_enabled <= mask_enabled_next;
      mask_key     <= mask_key_next;
      key_index    <= key_index_next;
      current_kind <= current_kind_next;
    end
  end

  a_payload_not_error: assert property (@(posedge clk) disable iff (rst)
    (step && emit && res.payload_valid) |-> (res.frame_kind != KIND_ERROR))
    else $error("payload transfer tagged as error frame");

  a_marker_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (step && emit && !res.payload_valid) |-> res.frame_end)
    else $error("data-less result without frame end");

  a_last_key_to_payload: assert property (@(posedge clk) disable iff (rst)
    (step && parse_phase == PH_KEY && skip_count == 4'd1)
      |=> (parse_phase == PH_PAYLOAD || parse_phase == PH_OPCODE))
    else $error("last key byte did not open the payload");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    skip_count <= SKIP_EXT64)
    else $error("skip count out of range");

endmodule

// ===== hw/rtl/wsfu_out_stage.sv =====
module wsfu_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              emit,
  input  wsfu_pkg::result_t res,
  output logic              free,
  output logic              result_valid,
  input  logic              result_stall,
  output wsfu_pkg::result_t result
);
  import wsfu_pkg::*;

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (free && step && emit) begin
      result <= res;
    end
  end

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.payload_valid) |-> (result.payload_byte == '0))
    else $error("data-less result carries a nonzero byte");

endmodule

// ===== hw/rtl/websocket_frame_unmasker_top.sv =====
// websocket frame unmasker
// input channel: one byte of a received frame per transfer (rx_byte), with
// buffer_end set on the final byte of the frame buffer; byte_valid/byte_stall
// output channel: at most one result per input byte (payload_byte,
// payload_valid, frame_kind, frame_end); result_valid/result_stall
// header bytes (opcode, length, extension, key) give no result unless the
// buffer ends on them, then a data-less end marker is sent
// an unsupported opcode gives one error result and the rest of the frame
// up to buffer_end is dropped
// a byte passes the input register, then parse logic into the result
// register
// throughput: one byte per cycle unless stalled; one parse step per byte
// reset (rst, synchronous) empties both registers and returns the parser
// to the opcode byte with an all-zero mask key
// while result_stall holds a pending result, byte_stall rises once the
// input register is also full; nothing is lost or repeated
module websocket_frame_unmasker_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [wsfu_pkg::ByteW-1:0] rx_byte,
  input  logic                      buffer_end,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [wsfu_pkg::ByteW-1:0] payload_byte,
  output logic                      payload_valid,
  output logic [wsfu_pkg::KindW-1:0] frame_kind,
  output logic                      frame_end
);
  import wsfu_pkg::*;

  logic             free;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             held_end;
  logic             step;
  logic             emit;
  result_t          res;
  result_t          result;

  assign step = held_valid && free;

  wsfu_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .rx_byte         (rx_byte),
    .buffer_end      (buffer_end),
    .downstream_free (free),
    .held_valid      (held_valid),
    .held_byte       (held_byte),
    .held_end        (held_end)
  );

  wsfu_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_byte    (held_byte),
    .buffer_end (held_end),
    .emit       (emit),
    .res        (res)
  );

  wsfu_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .emit         (emit),
    .res          (res),
    .free         (free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign payload_byte  = result.payload_byte;
  assign payload_valid = result.payload_valid;
  assign frame_kind    = result.frame_kind;
  assign frame_end     = result.frame_end;

endmodule
